/* design/osvl_pkg.sv */
// Shared constants, types and helpers for the oversampled state-variable lowpass.
package osvl_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned SampleShift = 29 - SampleW;
  localparam int unsigned CutW = 17;
  localparam int unsigned AccW = 32;

  localparam logic [16:0] OneQ16 = 17'd65536;
  localparam logic [29:0] FxScale = 30'd557758033;
  localparam logic [29:0] C3Q30 = 30'd178956971;
  localparam logic [29:0] C5Q30 = 30'd8947849;
  localparam logic [29:0] C7Q30 = 30'd213044;

  // ceil(2^33 / 3): floor(n / 3) == (n * RecipThird) >> 33 for any n below 2^33.
  localparam logic [31:0] RecipThird = 32'd2863311531;

  // Output saturation limits in the widened mean format.
  localparam logic signed [37:0] OutMax = 38'((64'sd1 <<< (SampleW - 1)) - 64'sd1);
  localparam logic signed [37:0] OutMin = -OutMax - 38'sd1;

  localparam logic [0:0] RegResonance = 1'b0;
  localparam logic [0:0] RegMinCutoff = 1'b1;

  localparam int unsigned QDepth = 2;

  // Item handed from the front part to the back part.
  typedef struct packed {
    logic signed [AccW-1:0] x;
    logic [16:0] cut;
  } osvl_job_t;

  function automatic logic signed [AccW-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[AccW-1:0];
  endfunction

  // Round-half-away shift of a signed product.
  function automatic logic signed [63:0] rsr(input logic signed [63:0] v,
                                             input int unsigned s);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r = (mag + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

endpackage

/* design/osvl_front.sv */
// Input side: accepts items, scales the sample and clamps the cutoff into a queue.
module osvl_front import osvl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [SampleW-1:0] sample_i,
  input  logic [16:0] cut_i,
  input  logic [16:0] min_cut_i,
  output logic q_valid_o,
  input  logic q_pop_i,
  output osvl_job_t q_job_o
);
  osvl_job_t mem_q [QDepth];
  logic [0:0] wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push;
  logic [16:0] lo, c;
  osvl_job_t job;

  assign s_tready = (cnt_q != 2'(QDepth));
  assign push = s_tvalid && s_tready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_job_o = mem_q[rp_q];

  always_comb begin
    lo = (min_cut_i > OneQ16) ? OneQ16 : min_cut_i;
    c = cut_i;
    if (c < lo) c = lo;
    if (c > OneQ16) c = OneQ16;
    job.cut = c;
    job.x = AccW'($signed(sample_i)) <<< SampleShift;
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= job;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (q_pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end
endmodule

/* design/osvl_back.sv */
// Sequencer: sine series, three filter iterations and output mean, one multiply a step.
module osvl_back import osvl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  output logic q_pop_o,
  input  osvl_job_t q_job_i,
  input  logic [16:0] res_i,
  output logic m_tvalid,
  input  logic m_tready,
  output logic [SampleW-1:0] y_o,
  output logic busy_o
);
  localparam logic [4:0] SIdle = 5'd0, SFx = 5'd1, SF2 = 5'd2, SF3 = 5'd3,
    SF5 = 5'd4, SF7 = 5'd5, ST3 = 5'd6, ST5 = 5'd7, ST7 = 5'd8, SLp = 5'd9,
    SDp = 5'd10, SHp = 5'd11, SBp = 5'd12, SMean = 5'd13, SOut = 5'd14;

  logic [4:0] st_q, st_d;
  logic [1:0] it_q;
  logic [31:0] fx_q, f2_q, f3_q, f5_q, f7_q;
  logic [33:0] s_q;
  logic signed [31:0] f_q, lp_q, bp_q, hp_q, x_q;
  logic signed [35:0] sum_q;
  logic [16:0] dmp_q;
  logic [31:0] mq_q;
  logic [SampleW-1:0] y_q;
  logic v_q;
  logic out_go;
  logic [31:0] ma, mb;
  logic [63:0] mp, ur;
  logic signed [63:0] sp;
  logic [36:0] mag;
  logic [32:0] nn;
  logic [64:0] prod;
  logic signed [37:0] mean, yv;

  assign busy_o = (st_q != SIdle) || v_q;
  assign q_pop_o = (st_q == SIdle) && q_valid_i;
  // Last step loads the output register once it is free or being taken.
  assign out_go = (st_q == SOut) && (!v_q || m_tready);
  assign m_tvalid = v_q;
  assign y_o = y_q;

  // Shared unsigned and signed multipliers; operands picked by step.
  always_comb begin
    ma = '0;
    mb = '0;
    case (st_q)
      SFx: begin ma = fx_q; mb = 32'(FxScale); end
      SF2: begin ma = fx_q; mb = fx_q; end
      SF3: begin ma = f2_q; mb = fx_q; end
      SF5: begin ma = f3_q; mb = f2_q; end
      SF7: begin ma = f5_q; mb = f2_q; end
      ST3: begin ma = f3_q; mb = 32'(C3Q30); end
      ST5: begin ma = f5_q; mb = 32'(C5Q30); end
      ST7: begin ma = f7_q; mb = 32'(C7Q30); end
      default: ;
    endcase
    mp = 64'(ma) * 64'(mb);
    ur = (mp + (64'd1 << 29)) >> 30;
    sp = '0;
    case (st_q)
      SLp: sp = 64'(f_q) * 64'(bp_q);
      SDp: sp = 64'($signed({1'b0, dmp_q})) * 64'(bp_q);
      SHp: sp = 64'(f_q) * 64'(hp_q);
      default: ;
    endcase
    // Divide by three through the reciprocal, rounded as (|sum| + 1) / 3.
    mag = sum_q[35] ? 37'(-sum_q) : 37'(sum_q);
    nn = 33'(mag) + 33'd1;
    prod = 65'(nn) * 65'(RecipThird);
    mean = sum_q[35] ? -$signed({6'd0, mq_q}) : $signed({6'd0, mq_q});
    yv = 38'(rsr(64'(mean), SampleShift));
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      SIdle: if (q_pop_o) st_d = SFx;
      SFx: st_d = SF2;
      SF2: st_d = SF3;
      SF3: st_d = SF5;
      SF5: st_d = SF7;
      SF7: st_d = ST3;
      ST3: st_d = ST5;
      ST5: st_d = ST7;
      ST7: st_d = SLp;
      SLp: st_d = SDp;
      SDp: st_d = SHp;
      SHp: st_d = SBp;
      SBp: st_d = (it_q == 2'd2) ? SMean : SLp;
      SMean: st_d = SOut;
      SOut: st_d = out_go ? SIdle : SOut;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      SIdle: if (q_pop_o) begin
        x_q <= q_job_i.x;
        fx_q <= {15'd0, q_job_i.cut};
        dmp_q <= OneQ16 - ((res_i > OneQ16) ? OneQ16 : res_i);
      end
      SFx: begin
        fx_q <= 32'((mp + 64'd32768) >> 16);
        x_q <= x_q;
      end
      SF2: f2_q <= ur[31:0];
      SF3: begin f3_q <= ur[31:0]; s_q <= 34'(fx_q); end
      SF5: f5_q <= ur[31:0];
      SF7: f7_q <= ur[31:0];
      ST3: s_q <= s_q - 34'(ur);
      ST5: s_q <= s_q + 34'(ur);
      ST7: begin
        f_q <= 32'((s_q - 34'(ur)) << 1);
        sum_q <= '0;
      end
      SDp: hp_q <= sat32(64'(x_q) - 64'(lp_q) - rsr(sp, 16));
      SBp: sum_q <= sum_q + 36'(lp_q);
      SMean: mq_q <= prod[64:33];
      default: ;
    endcase
    if (out_go) begin
      if (yv > OutMax) y_q <= OutMax[SampleW-1:0];
      else if (yv < OutMin) y_q <= OutMin[SampleW-1:0];
      else y_q <= yv[SampleW-1:0];
    end
  end

  // Integrators and control need reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      it_q <= '0;
      v_q <= 1'b0;
      lp_q <= '0;
      bp_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == ST7) it_q <= '0;
      else if (st_q == SBp) it_q <= it_q + 2'd1;
      if (st_q == SLp) lp_q <= sat32(64'(lp_q) + rsr(sp, 30));
      if (st_q == SHp) bp_q <= sat32(rsr(sp, 30) + 64'(bp_q));
      if (out_go) v_q <= 1'b1;
      else if (m_tready) v_q <= 1'b0;
    end
  end
endmodule

/* design/oversampled_state_variable_lowpass.sv */
// Top level of the oversampled state-variable lowpass filter.
// Per item the back sequencer pops the queue, uses one shared 32x32 multiplier for the
// cutoff scale, the four sine-series powers and three series terms, runs three filter
// passes of four steps each on a second signed multiplier, forms the divide-by-three
// mean and loads the output register. It pops the next item only once the last one has
// loaded the output register. A result still waiting on the output register holds the
// sequencer in its last step. A two-entry queue lets the input side take items while
// the sequencer works. Resonance and min_cutoff are written over the cfg port at index
// 0 and 1; other indexes are ignored.
module oversampled_state_variable_lowpass import osvl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [47:0] s_axis_tdata, // [23:0] sample_in, [40:24] cutoff, rest zero
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [23:0] m_axis_tdata, // [23:0] lowpass_out
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [0:0] cfg_index_i,
  input  logic [16:0] cfg_data_i
);
  logic [16:0] res_q, minc_q;
  logic qv, qpop, busy;
  osvl_job_t qj;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= 17'd32768;
      minc_q <= 17'd27;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegResonance: res_q <= cfg_data_i;
        RegMinCutoff: minc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  osvl_front u_front (
    .clk_i, .rst_ni,
    .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
    .sample_i(s_axis_tdata[23:0]), .cut_i(s_axis_tdata[40:24]),
    .min_cut_i(minc_q), .q_valid_o(qv), .q_pop_i(qpop), .q_job_o(qj)
  );

  osvl_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(qv), .q_pop_o(qpop), .q_job_i(qj), .res_i(res_q),
    .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready), .y_o(m_axis_tdata),
    .busy_o(busy)
  );

`ifndef ASSERT_OFF
  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qpop |-> qv) else $error("pop from empty queue");
  a_busy_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qpop |=> busy) else $error("sequencer idle after pop");
`endif
endmodule
